/* rtl/core/mme_pkg.sv */
// shared types, codes and constants of the matrix multiply engine
package mme_pkg;

    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;

    localparam int DIM_W   = 4;
    localparam int ROW_W   = 3;
    localparam int COL_W   = 3;
    localparam int VALUE_W = 32;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [MODE_W-1:0] MODE_WR_A    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_B    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } mme_state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mme_issue_t;

    // zero reads as one, anything above the maximum reads as the maximum
    function automatic logic [DIM_W:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                 input int max_dim);
        logic [DIM_W:0] r;
        if (d == '0) begin
            r = (DIM_W+1)'(1);
        end else if (32'(d) > max_dim) begin
            r = (DIM_W+1)'(max_dim);
        end else begin
            r = {1'b0, d};
        end
        return r;
    endfunction

endpackage

/* rtl/core/mme_datapath.sv */
// element stores, shared multiply-accumulate unit and output rounding
module mme_datapath #(
    parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mme_pkg::FRAC_BITS_DEF,
    parameter int ADDR_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_a_en,
    input  logic                        wr_b_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [mme_pkg::VALUE_W-1:0] wr_data,
    input  mme_pkg::mme_issue_t         issue,
    input  logic [ADDR_W-1:0]           rd_addr_a,
    input  logic [ADDR_W-1:0]           rd_addr_b,
    input  logic                        take,
    output logic                        acc_done,
    output logic [mme_pkg::VALUE_W-1:0] res_value,
    output logic                        res_sat
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ACC_W = 2 * mme_pkg::VALUE_W + IDX_W + 1;
    localparam int VW    = mme_pkg::VALUE_W;

    logic [VW-1:0] mem_a [DEPTH];
    logic [VW-1:0] mem_b [DEPTH];

    logic [VW-1:0]        rd_a_reg;
    logic [VW-1:0]        rd_b_reg;
    mme_pkg::mme_issue_t  st1_reg;
    mme_pkg::mme_issue_t  st2_reg;
    logic signed [2*VW-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic                 acc_done_reg;
    logic signed [ACC_W-1:0] shifted;
    logic                 in_range;

    always_ff @(posedge aclk) begin
        if (wr_a_en) begin
            mem_a[wr_addr] <= wr_data;
        end
        if (wr_b_en) begin
            mem_b[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem_a[rd_addr_a];
        rd_b_reg <= mem_b[rd_addr_b];
    end

    always_comb begin
        if (st2_reg.first) begin
            acc_next = ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= $signed(rd_a_reg) * $signed(rd_b_reg);
        if (st2_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_reg      <= '0;
            st2_reg      <= '0;
            acc_done_reg <= 1'b0;
        end else begin
            st1_reg <= issue;
            st2_reg <= st1_reg;
            if (st2_reg.valid && st2_reg.last) begin
                acc_done_reg <= 1'b1;
            end else if (take) begin
                acc_done_reg <= 1'b0;
            end
        end
    end

    // arithmetic shift rounds toward minus infinity
    assign shifted  = acc_reg >>> FRAC_BITS;
    assign in_range = (&shifted[ACC_W-1:VW-1]) || !(|shifted[ACC_W-1:VW-1]);

    always_comb begin
        if (in_range) begin
            res_value = shifted[VW-1:0];
            res_sat   = 1'b0;
        end else if (shifted[ACC_W-1]) begin
            res_value = {1'b1, {(VW-1){1'b0}}};
            res_sat   = 1'b1;
        end else begin
            res_value = {1'b0, {(VW-1){1'b1}}};
            res_sat   = 1'b1;
        end
    end

    assign acc_done = acc_done_reg;

endmodule

/* rtl/core/matrix_multiply_engine.sv */
// matrix multiply engine top level: sequencer, configuration and stream ports
// compute: the sequencer issues the n terms of each element's dot product, n being the
// clamped inner dimension; reads, product, sum and output are each registered in turn
// throughput: writes one per cycle while idle; input is refused during a compute, whose
// elements take turns on the single multiply-accumulate unit, fed by one read port per store
// reset: synchronous, active low; clears the sequencer, handshakes and the dimension
// registers (each back to 1); stores hold no defined contents until written
module matrix_multiply_engine #(
    parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mme_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // mode[1:0], row[4:2], col[7:5], value[39:8]
    input  logic [mme_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_row[2:0], out_col[5:3], out_value[37:6], zero[39:38]
    output logic [mme_pkg::M_TDATA_W-1:0]   m_tdata,
    // saturated[0]
    output logic                            m_tuser,
    output logic                            m_tlast
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int VW     = mme_pkg::VALUE_W;

    logic [mme_pkg::DIM_W-1:0] rows_a_reg;
    logic [mme_pkg::DIM_W-1:0] inner_dim_reg;
    logic [mme_pkg::DIM_W-1:0] cols_b_reg;

    mme_pkg::mme_state_t state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] s_reg, s_next;
    logic [IDX_W-1:0] m_last, n_last, k_last;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [mme_pkg::ROW_W-1:0] out_row_reg;
    logic [mme_pkg::COL_W-1:0] out_col_reg;
    logic [VW-1:0]        out_value_reg;
    logic                 out_sat_reg;
    logic                 out_last_reg;
    logic                 out_load;
    logic                 elem_last;

    logic [mme_pkg::MODE_W-1:0] in_mode;
    logic [mme_pkg::ROW_W-1:0]  in_row;
    logic [mme_pkg::COL_W-1:0]  in_col;
    logic [VW-1:0]              in_value;
    logic                       in_accept;
    logic                       wr_ok;
    logic                       wr_a_en, wr_b_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr_a, rd_addr_b;

    mme_pkg::mme_issue_t issue;
    logic                take;
    logic                acc_done;
    logic [VW-1:0]       res_value;
    logic                res_sat;

    assign in_mode  = s_tdata[1:0];
    assign in_row   = s_tdata[4:2];
    assign in_col   = s_tdata[7:5];
    assign in_value = s_tdata[39:8];

    assign s_tready  = (state_reg == mme_pkg::S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign m_last = IDX_W'(mme_pkg::clamp_dim(rows_a_reg, MAX_DIM) - 1'b1);
    assign n_last = IDX_W'(mme_pkg::clamp_dim(inner_dim_reg, MAX_DIM) - 1'b1);
    assign k_last = IDX_W'(mme_pkg::clamp_dim(cols_b_reg, MAX_DIM) - 1'b1);

    assign wr_ok   = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
    assign wr_a_en = in_accept && wr_ok && (in_mode == mme_pkg::MODE_WR_A);
    assign wr_b_en = in_accept && wr_ok && (in_mode == mme_pkg::MODE_WR_B);
    assign wr_addr = ADDR_W'(32'(in_row) * MAX_DIM + 32'(in_col));

    assign rd_addr_a = ADDR_W'(32'(i_reg) * MAX_DIM + 32'(s_reg));
    assign rd_addr_b = ADDR_W'(32'(s_reg) * MAX_DIM + 32'(j_reg));

    assign elem_last = (i_reg == m_last) && (j_reg == k_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg    <= mme_pkg::DIM_W'(1);
            inner_dim_reg <= mme_pkg::DIM_W'(1);
            cols_b_reg    <= mme_pkg::DIM_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                mme_pkg::REG_ROWS_A:    rows_a_reg    <= cfg_wdata;
                mme_pkg::REG_INNER_DIM: inner_dim_reg <= cfg_wdata;
                mme_pkg::REG_COLS_B:    cols_b_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        s_next        = s_reg;
        issue         = '0;
        take          = 1'b0;
        out_load      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            mme_pkg::S_IDLE: begin
                if (s_tvalid && in_mode == mme_pkg::MODE_COMPUTE) begin
                    i_next     = '0;
                    j_next     = '0;
                    s_next     = '0;
                    state_next = mme_pkg::S_ISSUE;
                end
            end
            mme_pkg::S_ISSUE: begin
                issue.valid = 1'b1;
                issue.first = (s_reg == '0);
                issue.last  = (s_reg == n_last);
                if (s_reg == n_last) begin
                    s_next     = '0;
                    state_next = mme_pkg::S_DRAIN;
                end else begin
                    s_next = s_reg + 1'b1;
                end
            end
            mme_pkg::S_DRAIN: begin
                if (acc_done && (!m_tvalid_reg || m_tready)) begin
                    take          = 1'b1;
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    if (elem_last) begin
                        state_next = mme_pkg::S_IDLE;
                    end else begin
                        state_next = mme_pkg::S_ISSUE;
                        if (j_reg == k_last) begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end else begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            default: state_next = mme_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mme_pkg::S_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            s_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            s_reg        <= s_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_row_reg   <= mme_pkg::ROW_W'(i_reg);
            out_col_reg   <= mme_pkg::COL_W'(j_reg);
            out_value_reg <= res_value;
            out_sat_reg   <= res_sat;
            out_last_reg  <= elem_last;
        end
    end

    mme_datapath #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS),
        .ADDR_W    (ADDR_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_a_en   (wr_a_en),
        .wr_b_en   (wr_b_en),
        .wr_addr   (wr_addr),
        .wr_data   (in_value),
        .issue     (issue),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .take      (take),
        .acc_done  (acc_done),
        .res_value (res_value),
        .res_sat   (res_sat)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_value_reg, out_col_reg, out_row_reg};
    assign m_tuser  = out_sat_reg;
    assign m_tlast  = out_last_reg;

    // a finished sum only waits while the sequencer drains
    a_done_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_done |-> state_reg == mme_pkg::S_DRAIN)
        else $error("finished sum outside drain");

    // element counters stay inside the product dimensions
    a_counters_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != mme_pkg::S_IDLE |-> i_reg <= m_last && j_reg <= k_last && s_reg <= n_last)
        else $error("element counter beyond dimension");

    // a result is loaded only into a free or draining output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !m_tvalid_reg || m_tready)
        else $error("pending result overwritten");

    // input is refused for the whole of a compute run
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_mode == mme_pkg::MODE_COMPUTE) |=> !s_tready)
        else $error("input accepted during compute");

endmodule

/* verif/mme_product_checker.sv */
// matrix multiply engine checker: tracks stores and dimensions, predicts and compares products
module mme_product_checker #(
    parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mme_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // mode[1:0], row[4:2], col[7:5], value[39:8]
    input  logic [mme_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // out_row[2:0], out_col[5:3], out_value[37:6], zero[39:38]
    input  logic [mme_pkg::M_TDATA_W-1:0]   m_tdata,
    // saturated[0]
    input  logic                            m_tuser,
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              pending
);
    import mme_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [VALUE_W-1:0] value;
        logic               clipped;
        logic               is_last;
    } product_elem_t;

    localparam logic signed [127:0] SAT_HI = 128'sh7fff_ffff;
    localparam logic signed [127:0] SAT_LO = -128'sh8000_0000;

    logic [VALUE_W-1:0] mat_a [MAX_DIM*MAX_DIM];
    logic [VALUE_W-1:0] mat_b [MAX_DIM*MAX_DIM];
    logic [DIM_W-1:0]   rows_cfg;
    logic [DIM_W-1:0]   inner_cfg;
    logic [DIM_W-1:0]   cols_cfg;
    product_elem_t      product_q [$];

    function automatic int eff_dim(input logic [DIM_W-1:0] d);
        if (d == '0) return 1;
        if (int'(d) > MAX_DIM) return MAX_DIM;
        return int'(d);
    endfunction

    // full-width dot products, floor shift, then clip to 32 bits
    function automatic void queue_product();
        int m;
        int n;
        int k;
        logic signed [127:0] acc;
        logic signed [127:0] sh;
        logic signed [63:0]  prod;
        product_elem_t       e;
        m = eff_dim(rows_cfg);
        n = eff_dim(inner_cfg);
        k = eff_dim(cols_cfg);
        for (int i = 0; i < m; i++) begin
            for (int j = 0; j < k; j++) begin
                acc = '0;
                for (int s = 0; s < n; s++) begin
                    prod = $signed(mat_a[i*MAX_DIM+s]) * $signed(mat_b[s*MAX_DIM+j]);
                    acc  = acc + prod;
                end
                sh = acc >>> FRAC_BITS;
                e.row     = ROW_W'(i);
                e.col     = COL_W'(j);
                e.is_last = (i == m - 1) && (j == k - 1);
                if (sh > SAT_HI) begin
                    e.value   = 32'h7fff_ffff;
                    e.clipped = 1'b1;
                end else if (sh < SAT_LO) begin
                    e.value   = 32'h8000_0000;
                    e.clipped = 1'b1;
                end else begin
                    e.value   = sh[VALUE_W-1:0];
                    e.clipped = 1'b0;
                end
                product_q.push_back(e);
            end
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        product_elem_t want;
        int            addr;
        if (!aresetn) begin
            rows_cfg   = DIM_W'(1);
            inner_cfg  = DIM_W'(1);
            cols_cfg   = DIM_W'(1);
            fail_count = 0;
            product_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ROWS_A:    rows_cfg  = cfg_wdata;
                    REG_INNER_DIM: inner_cfg = cfg_wdata;
                    REG_COLS_B:    cols_cfg  = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (product_q.size() == 0) begin
                    $error("product element row %0d col %0d with none expected",
                           m_tdata[2:0], m_tdata[5:3]);
                    fail_count++;
                end else begin
                    want = product_q.pop_front();
                    check_field("out_row", 32'(want.row), 32'(m_tdata[2:0]));
                    check_field("out_col", 32'(want.col), 32'(m_tdata[5:3]));
                    check_field("out_value", want.value, m_tdata[37:6]);
                    check_field("saturated", 32'(want.clipped), 32'(m_tuser));
                    check_field("last", 32'(want.is_last), 32'(m_tlast));
                end
            end
            if (s_tvalid && s_tready) begin
                addr = int'(s_tdata[4:2]) * MAX_DIM + int'(s_tdata[7:5]);
                case (s_tdata[1:0])
                    MODE_WR_A:    mat_a[addr] = s_tdata[39:8];
                    MODE_WR_B:    mat_b[addr] = s_tdata[39:8];
                    MODE_COMPUTE: queue_product();
                    default: ;
                endcase
            end
        end
        pending = product_q.size();
    end

endmodule

/* verif/tb.sv */
// matrix multiply engine testbench top: clock, reset, stimulus, sink and verdict
module tb;
    import mme_pkg::*;

    localparam int                PERIOD        = 8;
    localparam int                ITEMS_TARGET  = 100;
    localparam int                SETTLE_CYCLES = 20;
    localparam int                LONG_HOLD     = 400;
    localparam int                LIMIT_CYCLES  = 400000;
    localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    int                   fail_count;
    int                   pending;

    bit written_a [MAX_DIM_DEF*MAX_DIM_DEF];
    bit written_b [MAX_DIM_DEF*MAX_DIM_DEF];
    int ext_rows    = 1;
    int ext_inner   = 1;
    int ext_cols    = 1;
    int random_items = 0;
    int cycles      = 0;
    int stall_left  = 0;
    bit in_random   = 1'b0;
    bit quiet       = 1'b0;
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    bit hold_req    = 1'b0;
    bit hold_taken  = 1'b0;

    always #(PERIOD/2) aclk = ~aclk;

    matrix_multiply_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    mme_product_checker checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result sink: random back-pressure plus one long hold-off
    always @(negedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = LONG_HOLD;
        end else if (stall_left == 0 && sink_idle_on && !quiet &&
                     $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12);
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic int extent(input logic [DIM_W-1:0] d);
        if (d == '0) return 1;
        if (int'(d) > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(d);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: begin
                case ($urandom_range(0, 5))
                    0: v = 32'h7fff_ffff;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'hffff_ffff;
                    4: v = 32'h0001_0000;
                    default: v = 32'h0000_0001;
                endcase
            end
            2, 3: v = 32'($urandom_range(0, 262143)) - 32'd131072;
            default: v = {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
        endcase
        return v;
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col, input logic [VALUE_W-1:0] value);
        if (src_idle_on && !quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, col, row, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (mode == MODE_WR_A) written_a[int'(row)*MAX_DIM_DEF+int'(col)] = 1'b1;
        if (mode == MODE_WR_B) written_b[int'(row)*MAX_DIM_DEF+int'(col)] = 1'b1;
        if (in_random && mode != MODE_UNUSED) random_items++;
        if (random_items >= ITEMS_TARGET - 20) quiet = 1'b1;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] i,
                              input logic [DIM_W-1:0] c);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROWS_A;
        cfg_wdata <= r;
        @(negedge aclk);
        cfg_index <= REG_INNER_DIM;
        cfg_wdata <= i;
        @(negedge aclk);
        cfg_index <= REG_COLS_B;
        cfg_wdata <= c;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        ext_rows  = extent(r);
        ext_inner = extent(i);
        ext_cols  = extent(c);
    endtask

    task automatic operand_pair(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b);
        send_item(MODE_WR_A, '0, '0, a);
        send_item(MODE_WR_B, '0, '0, b);
        send_item(MODE_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
    endtask

    // never read an entry that has not been loaded
    task automatic fill_operands();
        for (int r = 0; r < ext_rows; r++)
            for (int s = 0; s < ext_inner; s++)
                if (!written_a[r*MAX_DIM_DEF+s])
                    send_item(MODE_WR_A, 3'(r), 3'(s), rand_value());
        for (int s = 0; s < ext_inner; s++)
            for (int c = 0; c < ext_cols; c++)
                if (!written_b[s*MAX_DIM_DEF+c])
                    send_item(MODE_WR_B, 3'(s), 3'(c), rand_value());
    endtask

    task automatic load_or_noise();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            if (pick[0])
                send_item(MODE_WR_A, 3'($urandom_range(0, ext_rows - 1)),
                          3'($urandom_range(0, ext_inner - 1)), rand_value());
            else
                send_item(MODE_WR_B, 3'($urandom_range(0, ext_inner - 1)),
                          3'($urandom_range(0, ext_cols - 1)), rand_value());
        end else if (pick < 17) begin
            send_item(pick[0] ? MODE_WR_A : MODE_WR_B, 3'($urandom), 3'($urandom),
                      rand_value());
        end else begin
            send_item(MODE_UNUSED, 3'($urandom), 3'($urandom), $urandom);
        end
    endtask

    task automatic run_phase(input int idx);
        logic [DIM_W-1:0] r;
        logic [DIM_W-1:0] i;
        logic [DIM_W-1:0] c;
        if (idx == 0) begin
            r = 4'd15; i = 4'd0; c = 4'd8;
        end else if (idx == 1) begin
            r = 4'd1; i = 4'd15; c = 4'd0;
        end else if ($urandom_range(0, 7) == 0) begin
            r = 4'($urandom_range(0, 15));
            i = 4'($urandom_range(0, 15));
            c = 4'($urandom_range(0, 15));
        end else begin
            r = 4'($urandom_range(1, 3));
            i = 4'($urandom_range(1, 3));
            c = 4'($urandom_range(1, 3));
        end
        write_dims(r, i, c);
        src_idle_on  = $urandom_range(0, 3) != 0;
        sink_idle_on = $urandom_range(0, 3) != 0;
        repeat ($urandom_range(0, 6)) load_or_noise();
        fill_operands();
        send_item(MODE_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
        if (idx == 0) begin
            // sink stalls while further transactions keep coming
            hold_req = 1'b1;
            send_item(MODE_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
            send_item(MODE_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
        end else if ($urandom_range(0, 2) == 0) begin
            send_item(MODE_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
        end
        repeat ($urandom_range(0, 3)) load_or_noise();
        settle();
    endtask

    initial begin : stimulus
        int phase;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // saturation both ways, exact clip bounds, floor rounding, zero
        operand_pair(32'h7fff_ffff, 32'h7fff_ffff);
        operand_pair(32'h8000_0000, 32'h7fff_ffff);
        operand_pair(32'h8000_0000, 32'h8000_0000);
        operand_pair(32'h0001_0000, 32'hffff_8000);
        operand_pair(32'h0000_0001, 32'hffff_ffff);
        operand_pair(32'h7fff_ffff, 32'h0001_0000);
        operand_pair(32'h8000_0000, 32'h0001_0000);
        operand_pair(32'h0000_0000, $urandom);
        send_item(MODE_UNUSED, 3'd7, 3'd7, 32'hffff_ffff);
        settle();

        in_random = 1'b1;
        phase = 0;
        while (random_items < ITEMS_TARGET) begin
            run_phase(phase);
            phase++;
        end
        settle();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/mme_pkg.sv
rtl/core/mme_datapath.sv
rtl/core/matrix_multiply_engine.sv
verif/mme_product_checker.sv
verif/tb.sv
